### rtl/core/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared widths, item records, state codes and helpers for the axis-angle
// rotation matrix core.
// ----------------------------------------------------------------------------
package aarm_pkg;

	localparam int AX_W    = 16;
	localparam int CEN_W   = 32;
	localparam int L2_W    = 32;
	localparam int TOL_W   = 29;
	localparam int U_W     = 33;
	localparam int OUT_W   = 40;
	localparam int IN_W    = 176;
	localparam int ODATA_W = 168;

	localparam int SQ_V_W  = 60;
	localparam int SQ_R_W  = 32;
	localparam int ROOT_W  = 30;
	localparam int QUO_W   = 32;
	localparam int DIVN_W  = 59;

	localparam int PROD_W  = 66;
	localparam int CROSS_W = 49;
	localparam int P_W     = 36;
	localparam int OMC_W   = 17;
	localparam int E_W     = 54;
	localparam int M_W     = 26;
	localparam int D_W     = 27;
	localparam int TP_W    = 59;
	localparam int ACC_W   = 62;
	localparam int RND_W   = 46;

	localparam int SQ_STEPS  = 30;
	localparam int DIV_STEPS = 32;
	localparam int CNT_W     = 5;

	localparam logic signed [AX_W-1:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [M_W-1:0]  ONE_Q16 = 26'sd65536;
	localparam logic [L2_W-1:0]        ONE_L2  = 32'h1000_0000;
	localparam logic [1:0]             ROW_LAST = 2'd2;

	typedef logic [AX_W-1:0]  ax_t;
	typedef logic [CEN_W-1:0] cen_t;
	typedef logic [U_W-1:0]   u_t;

	// item after classification, waiting in the queue
	typedef struct packed {
		ax_t             sn;
		ax_t             cs;
		ax_t  [2:0]      ax;
		cen_t [2:0]      cen;
		logic [L2_W-1:0] l2;
		logic            ident;
		logic            err;
	} fr_item_t;

	// item with its unit axis, ready for the row pipeline
	typedef struct packed {
		ax_t        sn;
		ax_t        cs;
		u_t   [2:0] u;
		cen_t [2:0] cen;
		logic       ident;
		logic       err;
	} nm_item_t;

	typedef enum logic [2:0] {
		NS_IDLE,
		NS_SQRT,
		NS_DSET,
		NS_DIV,
		NS_DONE
	} nm_state_t;

	// third axis index for an off-diagonal entry
	function automatic logic [1:0] oth_idx(input logic [1:0] r, input logic [1:0] c);
		logic [1:0] k;
		k = 2'd3 - r - c;
		if (r == c || k == 2'd3)
			k = r;
		return k;
	endfunction

	// off-diagonal entries that add the sine term
	function automatic logic add_cross(input logic [1:0] r, input logic [1:0] c);
		return (r == 2'd0 && c == 2'd2) || (r == 2'd1 && c == 2'd0) ||
			(r == 2'd2 && c == 2'd1);
	endfunction

	function automatic logic [OUT_W-1:0] sat40(input logic signed [RND_W-1:0] v);
		logic signed [RND_W-1:0] hi;
		logic signed [RND_W-1:0] lo;
		hi = RND_W'(64'sh7F_FFFF_FFFF);
		lo = -hi - RND_W'(64'sd1);
		if (v > hi)
			return hi[OUT_W-1:0];
		else if (v < lo)
			return lo[OUT_W-1:0];
		return v[OUT_W-1:0];
	endfunction

endpackage

### rtl/core/aarm_front.sv
// ----------------------------------------------------------------------------
// aarm_front
// Input register: unpacks an item, flags identity and zero axis, and forms
// the squared axis length.
// ----------------------------------------------------------------------------
module aarm_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [aarm_pkg::IN_W-1:0]   in_data,
	output aarm_pkg::fr_item_t          item,
	output logic                        item_valid,
	input  logic                        item_ready
);

	aarm_pkg::fr_item_t fr_q;
	aarm_pkg::fr_item_t fr_d;
	logic               fr_v_q;
	logic signed [aarm_pkg::L2_W-1:0] sq [3];

	always_comb begin
		fr_d.sn     = in_data[15:0];
		fr_d.cs     = in_data[31:16];
		fr_d.ax[0]  = in_data[47:32];
		fr_d.ax[1]  = in_data[63:48];
		fr_d.ax[2]  = in_data[79:64];
		fr_d.cen[0] = in_data[111:80];
		fr_d.cen[1] = in_data[143:112];
		fr_d.cen[2] = in_data[175:144];
		for (int i = 0; i < 3; i++)
			sq[i] = $signed(fr_d.ax[i]) * $signed(fr_d.ax[i]);
		fr_d.l2    = aarm_pkg::L2_W'(sq[0]) + aarm_pkg::L2_W'(sq[1]) +
			aarm_pkg::L2_W'(sq[2]);
		fr_d.err   = !(($signed(fr_d.sn) == '0) && ($signed(fr_d.cs) == aarm_pkg::ONE_Q14)) &&
			(fr_d.ax[0] == '0) && (fr_d.ax[1] == '0) && (fr_d.ax[2] == '0);
		// a zero axis also takes the identity path
		fr_d.ident = (($signed(fr_d.sn) == '0) && ($signed(fr_d.cs) == aarm_pkg::ONE_Q14)) ||
			fr_d.err;
	end

	assign in_ready   = !fr_v_q || item_ready;
	assign item_valid = fr_v_q;
	assign item       = fr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_v_q <= 1'b0;
		end else if (in_ready) begin
			fr_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fr_q <= fr_d;
		end
	end

endmodule

### rtl/core/aarm_fifo.sv
// ----------------------------------------------------------------------------
// aarm_fifo
// Two-entry queue between the front register and the normalizer.
// ----------------------------------------------------------------------------
module aarm_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  aarm_pkg::fr_item_t wr_item,
	input  logic               wr_valid,
	output logic               wr_ready,
	output aarm_pkg::fr_item_t rd_item,
	output logic               rd_valid,
	input  logic               rd_pop
);

	aarm_pkg::fr_item_t slot_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !rd_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!push && rd_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

### rtl/core/aarm_norm.sv
// ----------------------------------------------------------------------------
// aarm_norm
// Axis normalizer: bit-serial square root of the squared length, then three
// restoring dividers in parallel for the unit axis.
// ----------------------------------------------------------------------------
module aarm_norm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [aarm_pkg::TOL_W-1:0]   tol,
	input  aarm_pkg::fr_item_t           head,
	input  logic                         head_valid,
	output logic                         head_pop,
	output aarm_pkg::nm_item_t           item,
	output logic                         item_valid,
	input  logic                         item_ready
);

	aarm_pkg::nm_state_t state_q;
	aarm_pkg::nm_state_t state_d;

	logic [aarm_pkg::CNT_W-1:0]  cnt_q;
	aarm_pkg::ax_t               sn_q;
	aarm_pkg::ax_t               cs_q;
	aarm_pkg::ax_t  [2:0]        ax_q;
	aarm_pkg::cen_t [2:0]        cen_q;
	logic                        ident_q;
	logic                        err_q;
	logic [aarm_pkg::SQ_V_W-1:0] v_q;
	logic [aarm_pkg::SQ_R_W-1:0] rem_q;
	logic [aarm_pkg::ROOT_W-1:0] root_q;
	logic [aarm_pkg::ROOT_W-1:0] drem_q [3];
	logic [aarm_pkg::QUO_W-1:0]  dlo_q  [3];
	logic [aarm_pkg::QUO_W-1:0]  quo_q  [3];
	aarm_pkg::u_t                u_q    [3];

	logic [aarm_pkg::L2_W-1:0]   dev;
	logic                        need;
	logic [aarm_pkg::SQ_R_W+1:0] rem2;
	logic [aarm_pkg::SQ_R_W+1:0] trial;
	logic                        sq_ge;
	logic [aarm_pkg::ROOT_W:0]   r2   [3];
	logic                        d_ge [3];
	logic [aarm_pkg::ROOT_W-1:0] drem_n [3];
	logic [aarm_pkg::QUO_W-1:0]  quo_n  [3];
	logic [aarm_pkg::AX_W-1:0]   mag  [3];
	logic [aarm_pkg::DIVN_W-1:0] num  [3];

	always_comb begin
		dev   = (head.l2 >= aarm_pkg::ONE_L2) ? head.l2 - aarm_pkg::ONE_L2 :
			aarm_pkg::ONE_L2 - head.l2;
		need  = !head.ident && (dev > aarm_pkg::L2_W'(tol));
		rem2  = {rem_q, v_q[aarm_pkg::SQ_V_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		sq_ge = (rem2 >= trial);
		for (int i = 0; i < 3; i++) begin
			mag[i]    = ax_q[i][aarm_pkg::AX_W-1] ? (~ax_q[i] + 1'b1) : ax_q[i];
			num[i]    = {1'b0, mag[i], 42'd0} + aarm_pkg::DIVN_W'(root_q >> 1);
			r2[i]     = {drem_q[i], dlo_q[i][aarm_pkg::QUO_W-1]};
			d_ge[i]   = (r2[i] >= {1'b0, root_q});
			drem_n[i] = d_ge[i] ? aarm_pkg::ROOT_W'(r2[i] - {1'b0, root_q}) :
				aarm_pkg::ROOT_W'(r2[i]);
			quo_n[i]  = {quo_q[i][aarm_pkg::QUO_W-2:0], d_ge[i]};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			aarm_pkg::NS_IDLE: begin
				if (head_valid)
					state_d = need ? aarm_pkg::NS_SQRT : aarm_pkg::NS_DONE;
			end
			aarm_pkg::NS_SQRT: begin
				if (cnt_q == aarm_pkg::CNT_W'(aarm_pkg::SQ_STEPS - 1))
					state_d = aarm_pkg::NS_DSET;
			end
			aarm_pkg::NS_DSET: begin
				state_d = aarm_pkg::NS_DIV;
			end
			aarm_pkg::NS_DIV: begin
				if (cnt_q == aarm_pkg::CNT_W'(aarm_pkg::DIV_STEPS - 1))
					state_d = aarm_pkg::NS_DONE;
			end
			aarm_pkg::NS_DONE: begin
				if (item_ready)
					state_d = aarm_pkg::NS_IDLE;
			end
			default: begin
				state_d = aarm_pkg::NS_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		head_pop   = 1'b0;
		item_valid = 1'b0;
		case (state_q)
			aarm_pkg::NS_IDLE: head_pop = head_valid;
			aarm_pkg::NS_DONE: item_valid = 1'b1;
			default: begin
				head_pop   = 1'b0;
				item_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aarm_pkg::NS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == aarm_pkg::NS_SQRT || state_q == aarm_pkg::NS_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			aarm_pkg::NS_IDLE: begin
				if (head_valid) begin
					sn_q    <= head.sn;
					cs_q    <= head.cs;
					ax_q    <= head.ax;
					cen_q   <= head.cen;
					ident_q <= head.ident;
					err_q   <= head.err;
					v_q     <= {head.l2, 28'd0};
					rem_q   <= '0;
					root_q  <= '0;
					for (int i = 0; i < 3; i++)
						u_q[i] <= {head.ax[i][aarm_pkg::AX_W-1], head.ax[i], 16'd0};
				end
			end
			aarm_pkg::NS_SQRT: begin
				rem_q  <= sq_ge ? aarm_pkg::SQ_R_W'(rem2 - trial) : aarm_pkg::SQ_R_W'(rem2);
				root_q <= {root_q[aarm_pkg::ROOT_W-2:0], sq_ge};
				v_q    <= {v_q[aarm_pkg::SQ_V_W-3:0], 2'b00};
			end
			aarm_pkg::NS_DSET: begin
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= aarm_pkg::ROOT_W'(num[i][aarm_pkg::DIVN_W-1:aarm_pkg::QUO_W]);
					dlo_q[i]  <= num[i][aarm_pkg::QUO_W-1:0];
					quo_q[i]  <= '0;
				end
			end
			aarm_pkg::NS_DIV: begin
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= drem_n[i];
					dlo_q[i]  <= {dlo_q[i][aarm_pkg::QUO_W-2:0], 1'b0};
					quo_q[i]  <= quo_n[i];
					if (cnt_q == aarm_pkg::CNT_W'(aarm_pkg::DIV_STEPS - 1))
						u_q[i] <= ax_q[i][aarm_pkg::AX_W-1] ?
							-aarm_pkg::U_W'(quo_n[i]) : aarm_pkg::U_W'(quo_n[i]);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		item.sn    = sn_q;
		item.cs    = cs_q;
		item.cen   = cen_q;
		item.ident = ident_q;
		item.err   = err_q;
		for (int i = 0; i < 3; i++)
			item.u[i] = u_q[i];
	end

endmodule

### rtl/core/aarm_rows.sv
// ----------------------------------------------------------------------------
// aarm_rows
// Row pipeline: issues rows 0..2 one per cycle unless stalled, forms the
// Rodrigues entries and the centre-keeping translation, output register last.
// ----------------------------------------------------------------------------
module aarm_rows (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aarm_pkg::nm_item_t            it_in,
	input  logic                          it_valid,
	output logic                          it_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    row_index,
	output logic [aarm_pkg::OUT_W-1:0]    col0,
	output logic [aarm_pkg::OUT_W-1:0]    col1,
	output logic [aarm_pkg::OUT_W-1:0]    col2,
	output logic [aarm_pkg::OUT_W-1:0]    translation,
	output logic                          axis_error,
	output logic                          last_row
);

	logic en;
	logic take;

	aarm_pkg::nm_item_t it_q;
	logic               it_v_q;
	logic [1:0]         row_q;

	logic                                 v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic [1:0]                           row_s1, row_s2, row_s3, row_s4;
	logic                                 id_s1, id_s2, id_s3, id_s4;
	logic                                 er_s1, er_s2, er_s3, er_s4;
	aarm_pkg::ax_t                        cs_s1;
	aarm_pkg::cen_t [2:0]                 cen_s1, cen_s2, cen_s3;
	logic signed [aarm_pkg::PROD_W-1:0]   prod_s1  [3];
	logic signed [aarm_pkg::CROSS_W-1:0]  cross_s1 [3];
	logic signed [aarm_pkg::E_W-1:0]      e_s2     [3];
	logic signed [aarm_pkg::M_W-1:0]      m_s3     [3];
	logic signed [aarm_pkg::D_W-1:0]      d_s3     [3];
	logic signed [aarm_pkg::M_W-1:0]      m_s4     [3];
	logic signed [aarm_pkg::TP_W-1:0]     tp_s4    [3];

	logic [1:0]                  row_q_out;
	logic [aarm_pkg::OUT_W-1:0]  col_q [3];
	logic [aarm_pkg::OUT_W-1:0]  trans_q;
	logic                        err_q;

	// stage 1 inputs
	logic signed [aarm_pkg::U_W-1:0]      u_r;
	logic signed [aarm_pkg::PROD_W-1:0]   prod_d  [3];
	logic signed [aarm_pkg::CROSS_W-1:0]  cross_d [3];
	// stage 2 inputs
	logic signed [aarm_pkg::PROD_W-1:0]   prnd   [3];
	logic signed [aarm_pkg::P_W-1:0]      p      [3];
	logic signed [aarm_pkg::OMC_W-1:0]    omc;
	logic signed [aarm_pkg::E_W-1:0]      pe     [3];
	logic signed [aarm_pkg::E_W-1:0]      term   [3];
	logic signed [aarm_pkg::E_W-1:0]      e_d    [3];
	// stage 3 inputs
	logic signed [aarm_pkg::E_W-1:0]      ernd   [3];
	logic signed [aarm_pkg::M_W-1:0]      m_d    [3];
	logic signed [aarm_pkg::D_W-1:0]      d_d    [3];
	// stage 4 inputs
	logic signed [aarm_pkg::TP_W-1:0]     tp_d   [3];
	// output stage inputs
	logic signed [aarm_pkg::ACC_W-1:0]    acc;
	logic signed [aarm_pkg::ACC_W-1:0]    tr;
	logic [aarm_pkg::OUT_W-1:0]           trans_d;

	assign en       = !out_v_q || out_ready;
	assign it_ready = en && (!it_v_q || row_q == aarm_pkg::ROW_LAST);
	assign take     = it_valid && it_ready;

	always_comb begin
		u_r = $signed(it_q.u[row_q]);
		for (int c = 0; c < 3; c++) begin
			prod_d[c]  = u_r * $signed(it_q.u[c]);
			cross_d[c] = $signed(it_q.u[aarm_pkg::oth_idx(row_q, 2'(c))]) *
				$signed(it_q.sn);
		end
	end

	always_comb begin
		omc = $signed(aarm_pkg::OMC_W'(aarm_pkg::ONE_Q14)) - $signed(cs_s1);
		for (int c = 0; c < 3; c++) begin
			prnd[c] = prod_s1[c] + (aarm_pkg::PROD_W'(1) <<< 29);
			p[c]    = prnd[c][aarm_pkg::PROD_W-1:30];
			pe[c]   = p[c] * omc;
			if (row_s1 == 2'(c))
				term[c] = aarm_pkg::E_W'($signed(cs_s1)) <<< 30;
			else if (aarm_pkg::add_cross(row_s1, 2'(c)))
				term[c] = cross_s1[c];
			else
				term[c] = -aarm_pkg::E_W'(cross_s1[c]);
			e_d[c] = pe[c] + term[c];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ernd[c] = e_s2[c] + (aarm_pkg::E_W'(1) <<< 27);
			if (id_s2)
				m_d[c] = (row_s2 == 2'(c)) ? aarm_pkg::ONE_Q16 : '0;
			else
				m_d[c] = ernd[c][aarm_pkg::E_W-1:28];
			d_d[c] = (row_s2 == 2'(c)) ?
				aarm_pkg::D_W'(m_d[c]) - aarm_pkg::D_W'(aarm_pkg::ONE_Q16) :
				aarm_pkg::D_W'(m_d[c]);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++)
			tp_d[c] = d_s3[c] * $signed(cen_s3[c]);
	end

	always_comb begin
		acc = aarm_pkg::ACC_W'(tp_s4[0]) + aarm_pkg::ACC_W'(tp_s4[1]) +
			aarm_pkg::ACC_W'(tp_s4[2]);
		tr  = -acc + (aarm_pkg::ACC_W'(1) <<< 15);
		trans_d = id_s4 ? '0 : aarm_pkg::sat40(tr[aarm_pkg::ACC_W-1:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_v_q  <= 1'b0;
			row_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= it_v_q;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			out_v_q <= v_s4;
			if (it_v_q && row_q != aarm_pkg::ROW_LAST) begin
				row_q <= row_q + 2'd1;
			end else begin
				it_v_q <= take;
				row_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			it_q <= it_in;
		if (en) begin
			row_s1 <= row_q;
			id_s1  <= it_q.ident;
			er_s1  <= it_q.err;
			cs_s1  <= it_q.cs;
			cen_s1 <= it_q.cen;
			for (int c = 0; c < 3; c++) begin
				prod_s1[c]  <= prod_d[c];
				cross_s1[c] <= cross_d[c];
			end

			row_s2 <= row_s1;
			id_s2  <= id_s1;
			er_s2  <= er_s1;
			cen_s2 <= cen_s1;
			for (int c = 0; c < 3; c++)
				e_s2[c] <= e_d[c];

			row_s3 <= row_s2;
			id_s3  <= id_s2;
			er_s3  <= er_s2;
			cen_s3 <= cen_s2;
			for (int c = 0; c < 3; c++) begin
				m_s3[c] <= m_d[c];
				d_s3[c] <= d_d[c];
			end

			row_s4 <= row_s3;
			id_s4  <= id_s3;
			er_s4  <= er_s3;
			for (int c = 0; c < 3; c++) begin
				m_s4[c]  <= m_s3[c];
				tp_s4[c] <= tp_d[c];
			end

			row_q_out <= row_s4;
			err_q     <= er_s4;
			trans_q   <= trans_d;
			for (int c = 0; c < 3; c++)
				col_q[c] <= aarm_pkg::OUT_W'(m_s4[c]);
		end
	end

	assign out_valid   = out_v_q;
	assign row_index   = row_q_out;
	assign col0        = col_q[0];
	assign col1        = col_q[1];
	assign col2        = col_q[2];
	assign translation = trans_q;
	assign axis_error  = err_q;
	assign last_row    = (row_q_out == aarm_pkg::ROW_LAST);

endmodule

### rtl/core/axis_angle_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_core
// Rodrigues axis-angle to 3x4 affine rotation rows, fixed point, with a
// classifying front end, a two-entry queue, an iterative axis normalizer
// and a five-stage row pipeline.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata: sin, cos, axis x/y/z, centre x/y/z
//  m_axis   | out       | tdata: row, col0..col2, translation; tuser: error;
//           |           | tlast: final row
//  cfg      | in        | unit tolerance, write only
//
//  a unit-length axis (or identity, or zero axis) goes one row per cycle
//  through the row pipeline while m_axis is not stalled; the first row passes
//  the front register, the queue, the normalizer and the row stage registers
//  an axis that needs normalizing holds the normalizer for a load, 30
//  square-root steps, a setup, 32 divide steps and the handoff
//  reset clears all valid flags, the queue and the tolerance
//  a stalled m_axis holds the row pipeline; the queue fills up to two items
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// sin_value, cos_value, axis_x, axis_y, axis_z, center_x, center_y, center_z
	input  logic [aarm_pkg::IN_W-1:0]       s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// row_index, col0, col1, col2, translation, zero pad
	output logic [aarm_pkg::ODATA_W-1:0]    m_axis_tdata,
	// axis_error
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast,
	input  logic                            cfg_wr_en,
	input  logic [aarm_pkg::TOL_W-1:0]      cfg_wr_data
);

	logic [aarm_pkg::TOL_W-1:0] tol_q;

	aarm_pkg::fr_item_t fr_item;
	logic               fr_valid;
	logic               fr_ready;
	aarm_pkg::fr_item_t q_item;
	logic               q_valid;
	logic               q_pop;
	aarm_pkg::nm_item_t nm_item;
	logic               nm_valid;
	logic               nm_ready;

	logic [1:0]                 row_index;
	logic [aarm_pkg::OUT_W-1:0] col0, col1, col2, translation;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	aarm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.item       (fr_item),
		.item_valid (fr_valid),
		.item_ready (fr_ready)
	);

	aarm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (fr_item),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.rd_item  (q_item),
		.rd_valid (q_valid),
		.rd_pop   (q_pop)
	);

	aarm_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.tol        (tol_q),
		.head       (q_item),
		.head_valid (q_valid),
		.head_pop   (q_pop),
		.item       (nm_item),
		.item_valid (nm_valid),
		.item_ready (nm_ready)
	);

	aarm_rows u_rows (
		.clk         (clk),
		.arst_n      (arst_n),
		.it_in       (nm_item),
		.it_valid    (nm_valid),
		.it_ready    (nm_ready),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.row_index   (row_index),
		.col0        (col0),
		.col1        (col1),
		.col2        (col2),
		.translation (translation),
		.axis_error  (m_axis_tuser),
		.last_row    (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, translation, col2, col1, col0, row_index};

endmodule
